// File: rtl/gsbc_pkg.sv
// shared types, constants and arithmetic step functions for the stick and button conditioner
package gsbc_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PORT_MASK = 1'b1;

  localparam logic [7:0]        DEAD_ZONE_RST = 8'd0;
  localparam logic [3:0]        PORT_MASK_RST = 4'hF;
  localparam logic [7:0]        DEAD_ZONE_FULL = 8'd255;
  localparam logic signed [7:0] CLAMP_MAX = 8'sd85;
  localparam logic signed [7:0] CLAMP_MIN = -8'sd85;
  localparam logic [15:0]       FULL_SCALE = 16'd16384;

  typedef struct packed {
    logic [1:0]  port;
    logic        conn;
    logic        conn_edge;
    logic        disc_edge;
    logic [15:0] held;
    logic [15:0] pressed;
    logic [15:0] released;
    logic        neg_x;
    logic        neg_y;
    logic [6:0]  mag_x;
    logic [6:0]  mag_y;
    logic [13:0] m2;
  } gsbc_entry_t;

  typedef struct packed {
    logic [29:0] n;
    logic [30:0] res;
  } sqrt_state_t;

  typedef struct packed {
    logic [15:0] rem;
    logic [15:0] lo;
  } div_state_t;

  // one step of the bitwise integer square root
  function automatic sqrt_state_t sqrt_step(input logic [29:0] n, input logic [30:0] res,
                                            input logic [30:0] bitv);
    sqrt_state_t s;
    logic [31:0] t;
    t = {1'b0, res} + {1'b0, bitv};
    if ({2'b00, n} >= t) begin
      s.n   = n - t[29:0];
      s.res = (res >> 1) + bitv;
    end else begin
      s.n   = n;
      s.res = res >> 1;
    end
    return s;
  endfunction

  // one restoring division step, quotient bits shift into lo
  function automatic div_state_t div_step(input logic [15:0] rem, input logic [15:0] lo,
                                          input logic [15:0] dv);
    div_state_t d;
    logic [16:0] sh;
    sh = {rem, lo[15]};
    if (sh >= {1'b0, dv}) begin
      d.rem = 16'(sh - {1'b0, dv});
      d.lo  = {lo[14:0], 1'b1};
    end else begin
      d.rem = sh[15:0];
      d.lo  = {lo[14:0], 1'b0};
    end
    return d;
  endfunction

endpackage

// File: rtl/gsbc_front.sv
// front end: per-port history, button edges, stick clamp and squared magnitude
module gsbc_front import gsbc_pkg::*; #(
  parameter int NUM_PORTS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_port,
  input  logic              in_link_up,
  input  logic signed [7:0] in_raw_stick_x,
  input  logic signed [7:0] in_raw_stick_y,
  input  logic [15:0]       in_button_word,
  input  logic [3:0]        port_mask,
  input  logic              fifo_full,
  output logic              push,
  output gsbc_entry_t       entry
);

  localparam int PIDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

  logic [15:0]       prev_held_r [NUM_PORTS];
  logic              prev_conn_r [NUM_PORTS];
  logic [PIDX_W-1:0] pidx;
  logic              in_range;
  logic              conn;
  logic              was;
  logic [15:0]       old;
  logic signed [7:0] cx;
  logic signed [7:0] cy;
  logic [6:0]        ax;
  logic [6:0]        ay;
  logic [13:0]       sq_x;
  logic [13:0]       sq_y;

  assign in_ready = !fifo_full;
  assign push     = in_valid && in_ready;
  assign pidx     = PIDX_W'(in_port);
  assign in_range = int'(in_port) < NUM_PORTS;

  always_comb begin
    was  = in_range && prev_conn_r[pidx];
    old  = in_range ? prev_held_r[pidx] : 16'h0000;
    conn = in_range && in_link_up && port_mask[in_port];
    cx   = (in_raw_stick_x > CLAMP_MAX) ? CLAMP_MAX :
           (in_raw_stick_x < CLAMP_MIN) ? CLAMP_MIN : in_raw_stick_x;
    cy   = (in_raw_stick_y > CLAMP_MAX) ? CLAMP_MAX :
           (in_raw_stick_y < CLAMP_MIN) ? CLAMP_MIN : in_raw_stick_y;
    ax   = cx[7] ? 7'(-cx) : cx[6:0];
    ay   = cy[7] ? 7'(-cy) : cy[6:0];
    sq_x = ax * ax;
    sq_y = ay * ay;

    entry.port      = in_port;
    entry.conn      = conn;
    entry.conn_edge = conn && !was;
    entry.disc_edge = !conn && was;
    entry.held      = conn ? in_button_word : 16'h0000;
    entry.pressed   = conn ? (in_button_word & ~old) : 16'h0000;
    entry.released  = conn ? (old & ~in_button_word) : old;
    entry.neg_x     = cx[7];
    entry.neg_y     = cy[7];
    entry.mag_x     = ax;
    entry.mag_y     = ay;
    entry.m2        = sq_x + sq_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PORTS; i++) begin
        prev_held_r[i] <= 16'h0000;
        prev_conn_r[i] <= 1'b0;
      end
    end else if (push && in_range) begin
      prev_held_r[pidx] <= conn ? in_button_word : 16'h0000;
      prev_conn_r[pidx] <= conn;
    end
  end

endmodule

// File: rtl/gsbc_fifo.sv
// two-entry queue between front end and stick datapath
module gsbc_fifo import gsbc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  gsbc_entry_t push_entry,
  output logic        full,
  input  logic        pop,
  output logic        head_valid,
  output gsbc_entry_t head_entry
);

  gsbc_entry_t mem_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  count_r;

  assign full       = count_r == 2'd2;
  assign head_valid = count_r != 2'd0;
  assign head_entry = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

// File: rtl/gsbc_back.sv
// stick datapath: dead zone test, iterative root, scale and per-axis divide, result register
module gsbc_back import gsbc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         dead_zone,
  input  logic               head_valid,
  input  gsbc_entry_t        head_entry,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_port,
  output logic               out_is_connected,
  output logic               out_connect_edge,
  output logic               out_disconnect_edge,
  output logic [15:0]        out_held_bits,
  output logic [15:0]        out_pressed_bits,
  output logic [15:0]        out_released_bits,
  output logic signed [15:0] out_stick_x_norm,
  output logic signed [15:0] out_stick_y_norm
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SQRT, ST_SCALE_SET, ST_SCALE, ST_AXIS_SET, ST_AXIS, ST_OUT
  } state_t;

  state_t      state_r;
  gsbc_entry_t ent_r;
  logic        live_r;
  logic [29:0] n_r;
  logic [30:0] res_r;
  logic [30:0] bit_r;
  logic [14:0] s_r;
  logic [15:0] rem_a_r, lo_a_r, dv_a_r;
  logic [15:0] rem_b_r, lo_b_r, dv_b_r;
  logic [2:0]  cnt_r;
  logic        out_valid_r;

  logic [16:0] m2_x9;
  logic [15:0] dz_sq;
  logic        live;
  sqrt_state_t sq_a, sq_b;
  div_state_t  da_a, da_b, db_a, db_b;
  logic [15:0] r;
  logic [17:0] r3;
  logic [17:0] d256;
  logic [17:0] num;
  logic [7:0]  k;
  logic [16:0] k512;
  logic [22:0] dvd_s;
  logic [14:0] s_nxt;
  logic [21:0] prod_x, prod_y;
  logic [29:0] dvd_x, dvd_y;
  logic [15:0] mag_x, mag_y;
  logic        slot_free;

  assign out_valid = out_valid_r;
  assign pop       = (state_r == ST_IDLE) && head_valid;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    m2_x9  = ({3'b000, head_entry.m2} << 3) + 17'(head_entry.m2);
    dz_sq  = dead_zone * dead_zone;
    live   = head_entry.conn && (head_entry.m2 != 14'd0) && (m2_x9 > {1'b0, dz_sq});
    sq_a   = sqrt_step(n_r, res_r, bit_r);
    sq_b   = sqrt_step(sq_a.n, sq_a.res, bit_r >> 2);
    r      = res_r[15:0];
    r3     = 18'({r, 1'b0}) + 18'(r);
    d256   = 18'({dead_zone, 8'h00});
    num    = (r3 > d256) ? (r3 - d256) : 18'd0;
    k      = DEAD_ZONE_FULL - dead_zone;
    k512   = {k, 9'h000};
    dvd_s  = {num[16:0], 6'h00};
    da_a   = div_step(rem_a_r, lo_a_r, dv_a_r);
    da_b   = div_step(da_a.rem, da_a.lo, dv_a_r);
    db_a   = div_step(rem_b_r, lo_b_r, dv_b_r);
    db_b   = div_step(db_a.rem, db_a.lo, dv_b_r);
    s_nxt  = (da_b.lo > FULL_SCALE) ? FULL_SCALE[14:0] : da_b.lo[14:0];
    prod_x = ent_r.mag_x * s_r;
    prod_y = ent_r.mag_y * s_r;
    dvd_x  = 30'({prod_x, 9'h000}) + 30'(r);
    dvd_y  = 30'({prod_y, 9'h000}) + 30'(r);
    mag_x  = (lo_a_r > FULL_SCALE) ? FULL_SCALE : lo_a_r;
    mag_y  = (lo_b_r > FULL_SCALE) ? FULL_SCALE : lo_b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_OUT && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (head_valid) begin
            ent_r  <= head_entry;
            live_r <= live;
            n_r    <= {head_entry.m2, 16'h0000};
            res_r  <= '0;
            bit_r  <= 31'h4000_0000;
            state_r <= live ? ST_SQRT : ST_OUT;
          end
        end
        ST_SQRT: begin
          n_r   <= sq_b.n;
          res_r <= sq_b.res;
          bit_r <= bit_r >> 4;
          if (bit_r[2]) begin
            state_r <= ST_SCALE_SET;
          end
        end
        ST_SCALE_SET: begin
          cnt_r <= '0;
          if (dead_zone == DEAD_ZONE_FULL || num >= 18'(k512)) begin
            s_r     <= FULL_SCALE[14:0];
            state_r <= ST_AXIS_SET;
          end else begin
            rem_a_r <= 16'(dvd_s[22:16]);
            lo_a_r  <= dvd_s[15:0];
            dv_a_r  <= 16'(k);
            state_r <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          rem_a_r <= da_b.rem;
          lo_a_r  <= da_b.lo;
          cnt_r   <= cnt_r + 3'd1;
          if (cnt_r == 3'd7) begin
            s_r     <= s_nxt;
            state_r <= ST_AXIS_SET;
          end
        end
        ST_AXIS_SET: begin
          rem_a_r <= 16'(dvd_x[29:16]);
          lo_a_r  <= dvd_x[15:0];
          dv_a_r  <= {r[14:0], 1'b0};
          rem_b_r <= 16'(dvd_y[29:16]);
          lo_b_r  <= dvd_y[15:0];
          dv_b_r  <= {r[14:0], 1'b0};
          cnt_r   <= '0;
          state_r <= ST_AXIS;
        end
        ST_AXIS: begin
          rem_a_r <= da_b.rem;
          lo_a_r  <= da_b.lo;
          rem_b_r <= db_b.rem;
          lo_b_r  <= db_b.lo;
          cnt_r   <= cnt_r + 3'd1;
          if (cnt_r == 3'd7) begin
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (slot_free) begin
            out_port            <= ent_r.port;
            out_is_connected    <= ent_r.conn;
            out_connect_edge    <= ent_r.conn_edge;
            out_disconnect_edge <= ent_r.disc_edge;
            out_held_bits       <= ent_r.held;
            out_pressed_bits    <= ent_r.pressed;
            out_released_bits   <= ent_r.released;
            out_stick_x_norm    <= !live_r ? 16'sd0 :
                                   ent_r.neg_x ? -$signed(mag_x) : $signed(mag_x);
            out_stick_y_norm    <= !live_r ? 16'sd0 :
                                   ent_r.neg_y ? -$signed(mag_y) : $signed(mag_y);
            state_r             <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/gamepad_stick_button_conditioner.sv
// top level: configuration registers, front end, queue and stick datapath
// a disconnected port or a stick in the dead zone skips from idle straight to the output state;
// a live stick runs the root, scale and axis divide states; full scale skips the scale divide
// the datapath takes no new item until its result is registered, since the iterative root and
// divide unit is shared; a two-entry queue keeps accepting meanwhile until it is full
// reset (synchronous, rst_n low): port history cleared, dead zone 0, all ports enabled
module gamepad_stick_button_conditioner import gsbc_pkg::*; #(
  parameter int NUM_PORTS = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_port,
  input  logic                  in_link_up,
  input  logic signed [7:0]     in_raw_stick_x,
  input  logic signed [7:0]     in_raw_stick_y,
  input  logic [15:0]           in_button_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_port,
  output logic                  out_is_connected,
  output logic                  out_connect_edge,
  output logic                  out_disconnect_edge,
  output logic [15:0]           out_held_bits,
  output logic [15:0]           out_pressed_bits,
  output logic [15:0]           out_released_bits,
  output logic signed [15:0]    out_stick_x_norm,
  output logic signed [15:0]    out_stick_y_norm
);

  logic [7:0]  dead_zone_r;
  logic [3:0]  port_mask_r;
  logic        push;
  logic        fifo_full;
  logic        pop;
  logic        head_valid;
  gsbc_entry_t push_entry;
  gsbc_entry_t head_entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dead_zone_r <= DEAD_ZONE_RST;
      port_mask_r <= PORT_MASK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEAD_ZONE: dead_zone_r <= cfg_wdata;
        REG_PORT_MASK: port_mask_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  gsbc_front #(
    .NUM_PORTS(NUM_PORTS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_port        (in_port),
    .in_link_up     (in_link_up),
    .in_raw_stick_x (in_raw_stick_x),
    .in_raw_stick_y (in_raw_stick_y),
    .in_button_word (in_button_word),
    .port_mask      (port_mask_r),
    .fifo_full      (fifo_full),
    .push           (push),
    .entry          (push_entry)
  );

  gsbc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (fifo_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  gsbc_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .dead_zone           (dead_zone_r),
    .head_valid          (head_valid),
    .head_entry          (head_entry),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_port            (out_port),
    .out_is_connected    (out_is_connected),
    .out_connect_edge    (out_connect_edge),
    .out_disconnect_edge (out_disconnect_edge),
    .out_held_bits       (out_held_bits),
    .out_pressed_bits    (out_pressed_bits),
    .out_released_bits   (out_released_bits),
    .out_stick_x_norm    (out_stick_x_norm),
    .out_stick_y_norm    (out_stick_y_norm)
  );

endmodule

// File: rtl/gsbc_checker.sv
// port-level checks for the stick and button conditioner, bound to the top level
module gsbc_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [1:0]            out_port,
  input logic                  out_is_connected,
  input logic                  out_connect_edge,
  input logic                  out_disconnect_edge,
  input logic [15:0]           out_held_bits,
  input logic [15:0]           out_pressed_bits,
  input logic [15:0]           out_released_bits,
  input logic signed [15:0]    out_stick_x_norm,
  input logic signed [15:0]    out_stick_y_norm
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_held_bits) &&
      $stable(out_stick_x_norm) && $stable(out_stick_y_norm) && $stable(out_port))
    else $error("result changed while stalled");

  a_edges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_connect_edge && out_disconnect_edge) &&
      (out_is_connected || !out_connect_edge) && (!out_is_connected || !out_disconnect_edge))
    else $error("connect edges disagree with connected flag");

  a_disc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_connected |-> out_held_bits == 16'h0000 &&
      out_pressed_bits == 16'h0000 && out_stick_x_norm == 16'sd0 && out_stick_y_norm == 16'sd0)
    else $error("disconnected port reports activity");

  a_btn_edges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_connected |-> (out_pressed_bits & ~out_held_bits) == 16'h0000 &&
      (out_released_bits & out_held_bits) == 16'h0000)
    else $error("button edges inconsistent with held buttons");

  a_stick_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_stick_x_norm <= 16'sd16384 && out_stick_x_norm >= -16'sd16384 &&
      out_stick_y_norm <= 16'sd16384 && out_stick_y_norm >= -16'sd16384)
    else $error("stick output beyond full scale");

endmodule

bind gamepad_stick_button_conditioner gsbc_checker u_gsbc_checker (.*);

// File: tb/gamepad_stick_button_conditioner_tb.sv
// self-checking testbench for the gamepad stick and button conditioner
module gamepad_stick_button_conditioner_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gsbc_pkg::*;

  localparam int DRAIN_PAD      = 40;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_POLLS    = 140;

  typedef struct {
    logic [1:0]        port;
    logic              link;
    logic signed [7:0] rx;
    logic signed [7:0] ry;
    logic [15:0]       buttons;
  } poll_t;

  typedef struct {
    logic [1:0]         port;
    logic               conn;
    logic               conn_edge;
    logic               disc_edge;
    logic [15:0]        held;
    logic [15:0]        pressed;
    logic [15:0]        released;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
  } port_report_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic [1:0]            in_port;
  logic                  in_link_up;
  logic signed [7:0]     in_raw_stick_x;
  logic signed [7:0]     in_raw_stick_y;
  logic [15:0]           in_button_word;
  logic                  out_valid;
  logic                  out_ready;
  logic [1:0]            out_port;
  logic                  out_is_connected;
  logic                  out_connect_edge;
  logic                  out_disconnect_edge;
  logic [15:0]           out_held_bits;
  logic [15:0]           out_pressed_bits;
  logic [15:0]           out_released_bits;
  logic signed [15:0]    out_stick_x_norm;
  logic signed [15:0]    out_stick_y_norm;

  // predictor state
  logic [7:0]   dz_cur;
  logic [3:0]   mask_cur;
  logic [15:0]  held_prev [4];
  logic         conn_prev [4];
  port_report_t pending_reports [$];

  logic [15:0] last_buttons [4];
  bit          idle_off;
  int          fail_count;
  int          n_polls;
  int          n_live;
  int          n_checked;
  int          n_settings;

  gamepad_stick_button_conditioner i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_port             (in_port),
    .in_link_up          (in_link_up),
    .in_raw_stick_x      (in_raw_stick_x),
    .in_raw_stick_y      (in_raw_stick_y),
    .in_button_word      (in_button_word),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_port            (out_port),
    .out_is_connected    (out_is_connected),
    .out_connect_edge    (out_connect_edge),
    .out_disconnect_edge (out_disconnect_edge),
    .out_held_bits       (out_held_bits),
    .out_pressed_bits    (out_pressed_bits),
    .out_released_bits   (out_released_bits),
    .out_stick_x_norm    (out_stick_x_norm),
    .out_stick_y_norm    (out_stick_y_norm)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int idle_gap();
    int r;
    if (idle_off) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [15:0] scale_axis(input longint c, input longint s,
                                                    input longint r);
    longint a;
    longint v;
    a = (c < 0) ? -c : c;
    v = (2 * a * 256 * s + r) / (2 * r);
    if (v > 16384) v = 16384;
    return (c < 0) ? 16'(-v) : 16'(v);
  endfunction

  // radial dead zone with rescale, exact integer form
  function automatic void shape_stick(input logic signed [7:0] rx, input logic signed [7:0] ry,
                                      output logic signed [15:0] sx,
                                      output logic signed [15:0] sy);
    longint cx;
    longint cy;
    longint d;
    longint m2;
    longint n;
    longint r;
    longint s;
    longint num;
    longint q;
    cx = rx;
    cy = ry;
    cx = (cx > 85) ? 85 : ((cx < -85) ? -85 : cx);
    cy = (cy > 85) ? 85 : ((cy < -85) ? -85 : cy);
    d  = dz_cur;
    m2 = cx * cx + cy * cy;
    sx = '0;
    sy = '0;
    if (m2 == 0 || 9 * m2 <= d * d) return;
    n = m2 * 65536;
    r = longint'($sqrt(real'(n)));
    while (r * r > n) r--;
    while ((r + 1) * (r + 1) <= n) r++;
    if (d == 255) begin
      s = 16384;
    end else begin
      num = (3 * r > 256 * d) ? 3 * r - 256 * d : 0;
      q   = num * 16384 / (256 * (255 - d));
      s   = (q > 16384) ? 16384 : q;
    end
    sx = scale_axis(cx, s, r);
    sy = scale_axis(cy, s, r);
  endfunction

  function automatic port_report_t predict_report(input poll_t p);
    port_report_t rep;
    logic         live;
    logic [15:0]  old;
    rep = '{default: '0};
    rep.port = p.port;
    live = p.link && mask_cur[p.port];
    old = held_prev[p.port];
    rep.conn = live;
    rep.conn_edge = live && !conn_prev[p.port];
    rep.disc_edge = !live && conn_prev[p.port];
    if (!live) begin
      rep.released = old;
      held_prev[p.port] = '0;
      conn_prev[p.port] = 1'b0;
    end else begin
      rep.held = p.buttons;
      rep.pressed = p.buttons & ~old;
      rep.released = old & ~p.buttons;
      shape_stick(p.rx, p.ry, rep.sx, rep.sy);
      held_prev[p.port] = p.buttons;
      conn_prev[p.port] = 1'b1;
    end
    return rep;
  endfunction

  function automatic poll_t mk_poll(input logic [1:0] port, input logic link,
                                    input logic signed [7:0] rx, input logic signed [7:0] ry,
                                    input logic [15:0] buttons);
    poll_t p;
    p.port = port;
    p.link = link;
    p.rx = rx;
    p.ry = ry;
    p.buttons = buttons;
    return p;
  endfunction

  task automatic send_poll(input poll_t p);
    int           gap;
    port_report_t rep;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_port        <= p.port;
    in_link_up     <= p.link;
    in_raw_stick_x <= p.rx;
    in_raw_stick_y <= p.ry;
    in_button_word <= p.buttons;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rep = predict_report(p);
    pending_reports.push_back(rep);
    n_polls++;
    if (rep.sx != 0 || rep.sy != 0) n_live++;
  endtask

  task automatic wait_drained();
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  // both registers written back to back while the block is idle
  task automatic load_settings(input logic [7:0] dz, input logic [3:0] mask);
    in_valid <= 1'b0;
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= REG_DEAD_ZONE;
    cfg_wdata <= dz;
    @(posedge clk);
    cfg_index <= REG_PORT_MASK;
    cfg_wdata <= CFG_DATA_W'(mask);
    @(posedge clk);
    cfg_we <= 1'b0;
    dz_cur = dz;
    mask_cur = mask;
    n_settings++;
  endtask

  task automatic test_default_settings();
    send_poll(mk_poll(2'd0, 1'b1, 8'h7F, 8'h80, 16'hFFFF));
    send_poll(mk_poll(2'd0, 1'b1, 8'h00, 8'h00, 16'h00FF));
    send_poll(mk_poll(2'd1, 1'b1, 8'h80, 8'h7F, 16'hA5A5));
    send_poll(mk_poll(2'd1, 1'b0, 8'h01, 8'h01, 16'hFFFF));
    send_poll(mk_poll(2'd1, 1'b0, 8'h7F, 8'h7F, 16'h5A5A));
    send_poll(mk_poll(2'd2, 1'b1, 8'd85, 8'd85, 16'h8001));
    send_poll(mk_poll(2'd2, 1'b1, 8'h01, 8'h00, 16'h0001));
    send_poll(mk_poll(2'd3, 1'b1, 8'hFF, 8'hFF, 16'h7FFE));
    send_poll(mk_poll(2'd0, 1'b1, 8'hAB, 8'h00, 16'h0000));
  endtask

  task automatic test_dead_zone_edges();
    load_settings(8'd255, 4'hF);
    send_poll(mk_poll(2'd0, 1'b1, 8'h7F, 8'h7F, 16'h0F0F));
    send_poll(mk_poll(2'd0, 1'b1, 8'd85, 8'h00, 16'hF0F0));
    send_poll(mk_poll(2'd2, 1'b1, 8'd60, 8'd60, 16'h0001));
    send_poll(mk_poll(2'd2, 1'b1, 8'd70, 8'hC4, 16'h0002));
    load_settings(8'd128, 4'hF);
    send_poll(mk_poll(2'd3, 1'b1, 8'hAB, 8'h00, 16'h1111));
    send_poll(mk_poll(2'd3, 1'b1, 8'd40, 8'd40, 16'h2222));
    send_poll(mk_poll(2'd3, 1'b1, 8'd10, 8'h00, 16'h2222));
    load_settings(8'd1, 4'hF);
    send_poll(mk_poll(2'd0, 1'b1, 8'h01, 8'h00, 16'h0000));
    send_poll(mk_poll(2'd0, 1'b1, 8'h00, 8'hFF, 16'hFFFF));
  endtask

  task automatic test_port_enable_mask();
    load_settings(8'd0, 4'b0101);
    send_poll(mk_poll(2'd1, 1'b1, 8'h20, 8'h20, 16'hFFFF));
    send_poll(mk_poll(2'd0, 1'b1, 8'h30, 8'hD0, 16'h1234));
    send_poll(mk_poll(2'd3, 1'b1, 8'h10, 8'h10, 16'h4321));
    load_settings(8'd0, 4'h0);
    send_poll(mk_poll(2'd0, 1'b1, 8'h7F, 8'h7F, 16'hFFFF));
    send_poll(mk_poll(2'd2, 1'b1, 8'h7F, 8'h7F, 16'hFFFF));
    load_settings(8'd0, 4'hF);
    send_poll(mk_poll(2'd0, 1'b1, 8'h40, 8'h00, 16'h8000));
  endtask

  function automatic logic signed [7:0] pick_axis();
    logic signed [7:0] corner [8] = '{8'h7F, 8'h80, 8'd85, 8'hAB, 8'd86, 8'hAA, 8'h00, 8'hFF};
    if ($urandom_range(0, 3) == 0) return corner[$urandom_range(0, 7)];
    return 8'($urandom);
  endfunction

  task automatic test_random_polls();
    logic [7:0] dz_list [6] = '{8'd0, 8'd255, 8'd1, 8'd254, 8'd128, 8'd40};
    logic [3:0] mask_list [6] = '{4'hF, 4'hF, 4'h0, 4'hA, 4'hF, 4'h5};
    poll_t      p;
    int         phase;
    int         k;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase < 6) load_settings(dz_list[phase], mask_list[phase]);
      else load_settings(8'($urandom), ($urandom_range(0, 1) == 0) ? 4'hF : 4'($urandom));
      idle_off = (phase % 4 == 3);
      for (k = 0; k < PHASE_POLLS; k++) begin
        p.port = 2'($urandom);
        p.link = ($urandom_range(0, 9) != 0);
        p.rx = pick_axis();
        p.ry = pick_axis();
        case ($urandom_range(0, 19))
          0: p.buttons = 16'h0000;
          1, 2: p.buttons = 16'($urandom);
          default: p.buttons = last_buttons[p.port] ^ (16'($urandom) & 16'($urandom) & 16'($urandom));
        endcase
        last_buttons[p.port] = p.buttons;
        send_poll(p);
      end
    end
    idle_off = 1'b0;
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : check_reports
    port_report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        $error("result item with nothing expected, port %0d", out_port);
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        n_checked++;
        check_field("out_port", want.port, out_port);
        check_field("out_is_connected", want.conn, out_is_connected);
        check_field("out_connect_edge", want.conn_edge, out_connect_edge);
        check_field("out_disconnect_edge", want.disc_edge, out_disconnect_edge);
        check_field("out_held_bits", want.held, out_held_bits);
        check_field("out_pressed_bits", want.pressed, out_pressed_bits);
        check_field("out_released_bits", want.released, out_released_bits);
        check_field("out_stick_x_norm", want.sx, out_stick_x_norm);
        check_field("out_stick_y_norm", want.sy, out_stick_y_norm);
      end
    end
  end

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = idle_gap();
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("no item moved for %0d cycles, %0d results outstanding", WATCHDOG_LIMIT,
             pending_reports.size());
    $display("[gamepad_stick_button_conditioner] ERROR");
    $finish;
  end

  initial begin : run
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = REG_DEAD_ZONE;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_port        = '0;
    in_link_up     = 1'b0;
    in_raw_stick_x = '0;
    in_raw_stick_y = '0;
    in_button_word = '0;
    idle_off       = 1'b0;
    fail_count     = 0;
    n_polls        = 0;
    n_live         = 0;
    n_checked      = 0;
    n_settings     = 1;
    dz_cur         = DEAD_ZONE_RST;
    mask_cur       = PORT_MASK_RST;
    for (int i = 0; i < 4; i++) begin
      held_prev[i] = '0;
      conn_prev[i] = 1'b0;
      last_buttons[i] = '0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_settings();
    test_dead_zone_edges();
    test_port_enable_mask();
    test_random_polls();

    in_valid <= 1'b0;
    wait_drained();
    $display("polled %0d items under %0d register settings, %0d results checked",
             n_polls, n_settings, n_checked);
    $display("%0d results carried a conditioned stick outside the dead zone", n_live);
    if (fail_count == 0) begin
      $display("[gamepad_stick_button_conditioner] OK");
    end else begin
      $display("[gamepad_stick_button_conditioner] ERROR");
    end
    $finish;
  end

endmodule
